### design/linear_queue_with_indexed_delete_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear queue block
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_QUEUE_WITH_INDEXED_DELETE_TOP_ASSERT_SVH
`define LINEAR_QUEUE_WITH_INDEXED_DELETE_TOP_ASSERT_SVH

// Property that must hold at every clock edge
`define LQID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent implies consequent (consequent may carry a ## delay)
`define LQID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

### design/lqid_pkg.sv
// ----------------------------------------------------------------------------
// lqid_pkg
// Shared types and constants of the linear queue with indexed delete.
// ----------------------------------------------------------------------------
package lqid_pkg;

  // Default number of slots
  localparam int unsigned CAPACITY = 16;

  // Field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Operation codes (codes 5 to 7 are treated as no-ops)
  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 3'd0,
    OP_DEQ = 3'd1,
    OP_DEL = 3'd2,
    OP_CLR = 3'd3,
    OP_LEN = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  // Request payload
  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value_in;
    logic [INDEX_W-1:0]        slot_index;
  } req_t;

  // Result payload
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

endpackage

### design/lqid_ram.sv
// ----------------------------------------------------------------------------
// lqid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lqid_ram #(
  parameter int unsigned Width = lqid_pkg::VALUE_W,
  parameter int unsigned Depth = lqid_pkg::CAPACITY,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/linear_queue_with_indexed_delete_top.sv
// Enqueue, clear, length and refused requests: result registered in the cycle after
//   accept, next request may follow in the very next cycle (busy stays low).
// Dequeue: result registered from the RAM read data in S_DEQ; busy for one cycle.
// Delete at slot: moves (tail - 1 - slot) entries, one per cycle through the single
//   RAM port pair; busy during the moves, result registered after the last move.
// Reset clears head, tail and control; slot contents are left as they are.
// ----------------------------------------------------------------------------
// linear_queue_with_indexed_delete_top
// Array-backed linear queue of signed words with enqueue, dequeue, delete at
// slot, clear and length. Slot words live in a synchronous RAM; head and tail
// pointers and a shift sequencer live in registers here.
// ----------------------------------------------------------------------------
`include "linear_queue_with_indexed_delete_top_assert.svh"

module linear_queue_with_indexed_delete_top #(
  parameter int unsigned CAPACITY = lqid_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lqid_pkg::req_t req_i,
  output logic          valid_o,
  output lqid_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (PW > lqid_pkg::INDEX_W) ? PW : lqid_pkg::INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DEQ   = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [PW-1:0]       head_q, head_d;
  logic [PW-1:0]       tail_q, tail_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic                valid_q, valid_d;
  lqid_pkg::rsp_t      rsp_q, rsp_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [lqid_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

  logic                empty;
  logic [CW-1:0]       idx_ext, idx_next;
  logic                idx_ok, need_shift;
  logic [PW-1:0]       cur_ext, cur_plus2;
  logic                last_move;

  // Slot storage
  lqid_ram #(
    .Width (lqid_pkg::VALUE_W),
    .Depth (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pointer and index checks
  assign empty      = (head_q == tail_q);
  assign idx_ext    = CW'(req_i.slot_index);
  assign idx_next   = idx_ext + CW'(1);
  assign idx_ok     = (idx_ext >= CW'(head_q)) && (idx_ext < CW'(tail_q));
  assign need_shift = (idx_next < CW'(tail_q));
  // tail_q is already pulled back during a shift; last move writes slot tail_q - 1
  assign cur_ext    = PW'(cur_q);
  assign cur_plus2  = cur_ext + PW'(2);
  assign last_move  = ((cur_ext + PW'(1)) == tail_q);

  // Request decode and shift sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    valid_d   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail_q[AW-1:0];
    ram_wdata = req_i.value_in;
    ram_re    = 1'b0;
    ram_raddr = head_q[AW-1:0];
    rsp_d.value_out = '0;
    rsp_d.status    = lqid_pkg::ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          valid_d = 1'b1;
          unique case (lqid_pkg::op_e'(req_i.operation))
            lqid_pkg::OP_ENQ: begin
              if (tail_q == PW'(CAPACITY)) begin
                rsp_d.status = lqid_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                tail_d = tail_q + PW'(1);
              end
            end
            lqid_pkg::OP_DEQ: begin
              if (empty) begin
                rsp_d.status = lqid_pkg::ST_EMPTY;
              end else begin
                // read head now, answer when data returns
                ram_re  = 1'b1;
                head_d  = head_q + PW'(1);
                valid_d = 1'b0;
                state_d = S_DEQ;
              end
            end
            lqid_pkg::OP_DEL: begin
              if (empty) begin
                rsp_d.status = lqid_pkg::ST_EMPTY;
              end else if (!idx_ok) begin
                rsp_d.status = lqid_pkg::ST_BADIDX;
              end else begin
                tail_d = tail_q - PW'(1);
                if (need_shift) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_next[AW-1:0];
                  cur_d     = idx_ext[AW-1:0];
                  valid_d   = 1'b0;
                  state_d   = S_SHIFT;
                end
              end
            end
            lqid_pkg::OP_CLR: begin
              if (empty) begin
                rsp_d.status = lqid_pkg::ST_EMPTY;
              end
              head_d = '0;
              tail_d = '0;
            end
            lqid_pkg::OP_LEN: begin
              if (empty) begin
                rsp_d.status = lqid_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        valid_d         = 1'b1;
        rsp_d.value_out = ram_rdata;
        state_d         = S_IDLE;
      end
      S_SHIFT: begin
        // move slot cur+1 down to cur, fetch the next one unless this is the last move
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = ram_rdata;
        cur_d     = cur_q + AW'(1);
        if (last_move) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_plus2[AW-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase

    rsp_d.occupancy = lqid_pkg::OCC_W'(tail_d - head_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (valid_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Checks
  `LQID_ASSERT(a_ptr_order, (head_q <= tail_q) && (tail_q <= PW'(CAPACITY)), "pointer order broken")
  `LQID_ASSERT_IMP(a_deq_latency, start && !busy && !empty && (req_i.operation == lqid_pkg::OP_DEQ), ##2 valid_o, "dequeue result late")
  `LQID_ASSERT_IMP(a_shift_range, state_q == S_SHIFT, cur_ext < tail_q, "shift past tail")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the linear queue with indexed delete and checks every
// result against an in-bench queue model, or against the expected result of a
// typed row of a short directed table. The table covers the empty, full and
// bad-index paths. It is followed by random request streams that follow the
// model's head and tail, so deletes mostly hit occupied slots.
// ----------------------------------------------------------------------------
module testbench;
  import lqid_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int PLAN_ROWS    = 26;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 4;

  // One row of the directed table; reps > 1 repeats the request with value, value+1 and so on
  typedef struct {
    op_e                 op;
    logic signed [31:0]  value;
    logic [3:0]          index;
    int                  reps;
    bit                  typed;
    logic signed [31:0]  want_value;
    status_e             want_status;
    logic [4:0]          want_occ;
  } step_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  req_t   req;
  logic   rsp_valid;
  rsp_t   rsp;

  // Queue model state
  logic signed [31:0] model_slots [CAPACITY];
  logic [4:0]         model_head;
  logic [4:0]         model_tail;

  rsp_t   pending_results [$];
  int     mismatches;
  int     cycles;
  bit     idle_enabled;

  linear_queue_with_indexed_delete_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .valid_o (rsp_valid),
    .rsp_o   (rsp)
  );

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Apply one request to the model and return the result it gives
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   i;
    int   idx;
    res.value_out = '0;
    res.status    = ST_OK;
    idx = int'(r.slot_index);
    case (r.operation)
      OP_ENQ: begin
        if (model_tail >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          model_slots[model_tail] = r.value_in;
          model_tail++;
        end
      end
      OP_DEQ: begin
        if (model_head == model_tail || model_head >= CAPACITY) begin
          res.status = ST_EMPTY;
        end else begin
          res.value_out = model_slots[model_head];
          model_head++;
        end
      end
      OP_DEL: begin
        if (model_head == model_tail) begin
          res.status = ST_EMPTY;
        end else if (idx < model_head || idx >= model_tail) begin
          res.status = ST_BADIDX;
        end else begin
          // later entries move down one slot
          for (i = idx; i + 1 < model_tail && i + 1 < CAPACITY; i++)
            model_slots[i] = model_slots[i + 1];
          model_tail--;
        end
      end
      OP_CLR: begin
        if (model_head == model_tail) res.status = ST_EMPTY;
        model_head = '0;
        model_tail = '0;
      end
      OP_LEN: begin
        if (model_head == model_tail) res.status = ST_EMPTY;
      end
      default: ;
    endcase
    res.occupancy = model_tail - model_head;
    return res;
  endfunction

  // Present one request, hold it until accepted, then record its expected result
  task automatic issue_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    int   gap;
    if (idle_enabled && $urandom_range(99) < 34) begin
      gap = $urandom_range(2, 1);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    @(negedge clk_i);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    predicted = apply_request(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_for_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected value %0d status %0d occ %0d, got value %0d status %0d occ %0d",
               $realtime, what, want.value_out, want.status, want.occupancy,
               got.value_out, got.status, got.occupancy);
  endtask

  // Result check: each strobed result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && rsp_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with no request outstanding", '0, rsp);
      end else begin
        want = pending_results.pop_front();
        if (rsp.value_out !== want.value_out || rsp.status !== want.status ||
            rsp.occupancy !== want.occupancy)
          note_mismatch("result mismatch", want, rsp);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t plan [PLAN_ROWS];
    req_t      r;
    rsp_t      want;
    int        i;
    int        k;
    int        n;
    int        pick;

    rst_ni       = 1'b0;
    start        = 1'b0;
    req          = '0;
    mismatches   = 0;
    cycles       = 0;
    idle_enabled = 1'b1;
    model_head   = '0;
    model_tail   = '0;
    foreach (model_slots[j]) model_slots[j] = '0;

    // Directed table: empty queue, extremes, bad index, fill to full,
    // long shifts, then drain every slot so the queue is empty yet full
    plan = '{
      '{OP_LEN, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_DEQ, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_DEL, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_CLR, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_ENQ, 32'sh7FFFFFFF,   4'd0,  1,  1'b1, 32'sd0,          ST_OK,     5'd1},
      '{OP_ENQ, 32'sh80000000,   4'd0,  1,  1'b1, 32'sd0,          ST_OK,     5'd2},
      '{OP_ENQ, -32'sd1,         4'd15, 1,  1'b1, 32'sd0,          ST_OK,     5'd3},
      '{OP_ENQ, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_OK,     5'd4},
      '{OP_DEL, 32'sd0,          4'd15, 1,  1'b1, 32'sd0,          ST_BADIDX, 5'd4},
      '{OP_DEL, 32'sd0,          4'd1,  1,  1'b1, 32'sd0,          ST_OK,     5'd3},
      '{OP_DEQ, 32'sd0,          4'd0,  1,  1'b1, 32'sh7FFFFFFF,   ST_OK,     5'd2},
      '{OP_DEL, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_BADIDX, 5'd2},
      '{OP_LEN, -32'sd1,         4'd0,  1,  1'b1, 32'sd0,          ST_OK,     5'd2},
      '{OP_ENQ, 32'sh5A5A5A5A,   4'd0,  13, 1'b0, 32'sd0,          ST_OK,     5'd0},
      '{OP_ENQ, 32'sd1234,       4'd0,  1,  1'b1, 32'sd0,          ST_FULL,   5'd15},
      '{OP_DEL, 32'sd0,          4'd15, 1,  1'b0, 32'sd0,          ST_OK,     5'd0},
      '{OP_DEL, 32'sd0,          4'd1,  1,  1'b0, 32'sd0,          ST_OK,     5'd0},
      '{OP_ENQ, 32'shA5A5A5A5,   4'd0,  2,  1'b0, 32'sd0,          ST_OK,     5'd0},
      '{OP_DEQ, 32'sd0,          4'd0,  15, 1'b0, 32'sd0,          ST_OK,     5'd0},
      '{OP_DEQ, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_ENQ, 32'sh7FFFFFFF,   4'd0,  1,  1'b1, 32'sd0,          ST_FULL,   5'd0},
      '{OP_DEL, 32'sd0,          4'd15, 1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_LEN, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_CLR, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_EMPTY,  5'd0},
      '{OP_ENQ, 32'sd1,          4'd0,  1,  1'b1, 32'sd0,          ST_OK,     5'd1},
      '{OP_CLR, 32'sd0,          4'd0,  1,  1'b1, 32'sd0,          ST_OK,     5'd0}
    };

    // Reset
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    for (i = 0; i < PLAN_ROWS; i++) begin
      for (k = 0; k < plan[i].reps; k++) begin
        r.operation  = plan[i].op;
        r.value_in   = plan[i].value + k;
        r.slot_index = plan[i].index;
        want.value_out = plan[i].want_value;
        want.status    = plan[i].want_status;
        want.occupancy = plan[i].want_occ;
        issue_request(r, plan[i].typed, want);
      end
    end
    wait_for_drain();

    // Random part: op mix follows the model so deletes mostly land in range
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_enabled = (n < 400 || n >= 700);
      if (n == 900) wait_for_drain();
      r.value_in   = $urandom;
      r.slot_index = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (model_tail == CAPACITY && pick < 30) begin
        r.operation = OP_CLR;
      end else if (pick < 45) begin
        r.operation = OP_ENQ;
        if ($urandom_range(9) == 0)
          r.value_in = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      end else if (pick < 63) begin
        r.operation = OP_DEQ;
      end else if (pick < 83) begin
        r.operation = OP_DEL;
        if (model_tail != model_head && $urandom_range(4) != 0)
          r.slot_index = 4'($urandom_range(model_tail - 1, model_head));
      end else if (pick < 93) begin
        r.operation = OP_LEN;
      end else begin
        r.operation = OP_CLR;
      end
      issue_request(r, 1'b0, '0);
    end

    // Let the last results come back
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/lqid_pkg.sv
design/lqid_ram.sv
design/linear_queue_with_indexed_delete_top.sv
test/testbench.sv
